### rtl/core/fcsb_pkg.sv
// Shared types, constants and helper functions for the field change and strength bar block.
`timescale 1ns / 1ps
package fcsb_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int BAR_LEVELS  = 8;
  localparam int BAR_IDX_W   = $clog2(BAR_LEVELS);
  localparam int THRESH_W    = 10;
  localparam int CMP_W       = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam int QUIET_W     = 16;
  localparam int LED_W       = 4;
  localparam int SEL_W       = 2;
  localparam int RUN_W       = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int PROD_W      = SAMPLE_BITS + BAR_IDX_W + 1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [THRESH_W-1:0]    thresh_t;
  typedef logic [QUIET_W-1:0]     quiet_t;
  typedef logic [LED_W-1:0]       led_t;
  typedef logic [SEL_W-1:0]       sel_t;
  typedef logic [RUN_W-1:0]       run_t;
  typedef logic [BAR_IDX_W-1:0]   bar_idx_t;

  localparam quiet_t  QUIET_MAX       = {QUIET_W{1'b1}};
  localparam sample_t BASELINE_MARGIN = SAMPLE_BITS'(10);
  localparam thresh_t THRESH_RESET    = THRESH_W'(10);

  localparam logic OP_CAPTURE = 1'b0;

  localparam sel_t SEL_LOW  = SEL_W'(1);
  localparam sel_t SEL_HIGH = SEL_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = CFG_IDX_W'(1);

  localparam int LED_B = 1;
  localparam int LED_D = 3;

  localparam run_t RUN_DETECT   = RUN_W'(0);
  localparam run_t RUN_STRENGTH = RUN_W'(1);
  localparam run_t RUN_STOPPED  = RUN_W'(2);

  typedef enum logic [2:0] {
    MODE_DETECT   = 3'b001,
    MODE_STRENGTH = 3'b010,
    MODE_STOPPED  = 3'b100
  } mode_t;

  typedef struct packed {
    logic    capture;
    logic    step;
    logic    enable;
    thresh_t threshold;
  } chan_ctrl_t;

  typedef struct packed {
    logic    change;
    sample_t old_level;
    sample_t new_level;
    quiet_t  quiet_count;
  } chan_res_t;

  // Bar light patterns in LED bit order (bit0 A .. bit3 D); top step and beyond: all on.
  function automatic led_t bar_pattern(input bar_idx_t idx);
    led_t pat;
    case (idx)
      BAR_IDX_W'(0): pat = 4'h0;
      BAR_IDX_W'(1): pat = 4'h4;
      BAR_IDX_W'(2): pat = 4'h1;
      BAR_IDX_W'(3): pat = 4'h2;
      BAR_IDX_W'(4): pat = 4'h8;
      BAR_IDX_W'(5): pat = 4'hA;
      BAR_IDX_W'(6): pat = 4'hB;
      default:       pat = 4'hF;
    endcase
    return pat;
  endfunction

  function automatic run_t run_code(input mode_t mode);
    run_t code;
    case (mode)
      MODE_DETECT:   code = RUN_DETECT;
      MODE_STRENGTH: code = RUN_STRENGTH;
      default:       code = RUN_STOPPED;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/fcsb_in_if.sv
// Input channel: one capture or sample item per transfer.
`timescale 1ns / 1ps
interface fcsb_in_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic                button;
  fcsb_pkg::sample_t   low_band_sample;
  fcsb_pkg::sample_t   high_band_sample;

  modport source (output valid, output opcode, output button, output low_band_sample,
                  output high_band_sample, input ready);
  modport sink   (input valid, input opcode, input button, input low_band_sample,
                  input high_band_sample, output ready);
endinterface

### rtl/core/fcsb_out_if.sv
// Result channel: LED state, run mode and per-band change report per transfer.
`timescale 1ns / 1ps
interface fcsb_out_if;
  logic                valid;
  logic                ready;
  fcsb_pkg::led_t      leds;
  fcsb_pkg::run_t      run_mode;
  logic                low_change;
  fcsb_pkg::sample_t   low_old_level;
  fcsb_pkg::sample_t   low_new_level;
  fcsb_pkg::quiet_t    low_quiet_count;
  logic                high_change;
  fcsb_pkg::sample_t   high_old_level;
  fcsb_pkg::sample_t   high_new_level;
  fcsb_pkg::quiet_t    high_quiet_count;

  modport source (output valid, output leds, output run_mode,
                  output low_change, output low_old_level, output low_new_level,
                  output low_quiet_count, output high_change, output high_old_level,
                  output high_new_level, output high_quiet_count, input ready);
  modport sink   (input valid, input leds, input run_mode,
                  input low_change, input low_old_level, input low_new_level,
                  input low_quiet_count, input high_change, input high_old_level,
                  input high_new_level, input high_quiet_count, output ready);
endinterface

### rtl/core/fcsb_chan.sv
// One band: held level, peak, baseline and quiet count with change detection.
`timescale 1ns / 1ps
module fcsb_chan (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fcsb_pkg::chan_ctrl_t   ctrl,
  input  fcsb_pkg::sample_t      sample,
  output fcsb_pkg::chan_res_t    res,
  output logic                   dev_led,
  output fcsb_pkg::sample_t      level_nxt,
  output fcsb_pkg::sample_t      peak_nxt,
  output fcsb_pkg::sample_t      baseline
);

  fcsb_pkg::sample_t level_r;
  fcsb_pkg::sample_t peak_r;
  fcsb_pkg::sample_t baseline_r;
  fcsb_pkg::quiet_t  quiet_r;
  fcsb_pkg::sample_t baseline_nxt;
  fcsb_pkg::quiet_t  quiet_nxt;
  fcsb_pkg::sample_t diff;
  fcsb_pkg::sample_t dev;
  fcsb_pkg::quiet_t  quiet_inc;
  logic              over;

  assign diff      = (level_r > sample) ? (level_r - sample) : (sample - level_r);
  assign over      = fcsb_pkg::CMP_W'(diff) > fcsb_pkg::CMP_W'(ctrl.threshold);
  assign dev       = (level_r > baseline_r) ? (level_r - baseline_r) : (baseline_r - level_r);
  assign dev_led   = dev > fcsb_pkg::BASELINE_MARGIN;
  assign quiet_inc = (quiet_r == fcsb_pkg::QUIET_MAX) ? quiet_r : quiet_r + 1'b1;
  assign baseline  = baseline_r;

  always_comb begin
    level_nxt       = level_r;
    peak_nxt        = peak_r;
    baseline_nxt    = baseline_r;
    quiet_nxt       = quiet_r;
    res.change      = 1'b0;
    res.old_level   = level_r;
    res.new_level   = level_r;
    res.quiet_count = quiet_r;
    if (ctrl.capture) begin
      level_nxt       = sample;
      peak_nxt        = sample;
      baseline_nxt    = ctrl.enable ? sample : '0;
      quiet_nxt       = '0;
      res.old_level   = sample;
      res.new_level   = sample;
      res.quiet_count = '0;
    end else if (ctrl.step) begin
      res.quiet_count = quiet_inc;
      quiet_nxt       = quiet_inc;
      if (over) begin
        res.change = 1'b1;
        level_nxt  = sample;
        quiet_nxt  = '0;
        if (sample > peak_r) begin
          peak_nxt = sample;
        end
      end
      res.new_level = level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      peak_r     <= '0;
      baseline_r <= '0;
      quiet_r    <= '0;
    end else begin
      level_r    <= level_nxt;
      peak_r     <= peak_nxt;
      baseline_r <= baseline_nxt;
      quiet_r    <= quiet_nxt;
    end
  end

endmodule

### rtl/core/fcsb_bar.sv
// Strength bar: finds the first bar step that holds the level and its light pattern.
`timescale 1ns / 1ps
module fcsb_bar (
  input  fcsb_pkg::sample_t level,
  input  fcsb_pkg::sample_t peak,
  output logic              hit,
  output fcsb_pkg::led_t    pattern
);

  fcsb_pkg::sample_t step;
  fcsb_pkg::bar_idx_t idx;
  logic [fcsb_pkg::PROD_W-1:0] lo_bound [fcsb_pkg::BAR_LEVELS];
  logic [fcsb_pkg::PROD_W-1:0] hi_bound [fcsb_pkg::BAR_LEVELS];

  assign step = peak >> fcsb_pkg::BAR_IDX_W;

  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = fcsb_pkg::BAR_LEVELS - 1; i >= 0; i--) begin
      lo_bound[i] = fcsb_pkg::PROD_W'(step) * fcsb_pkg::PROD_W'(i);
      hi_bound[i] = fcsb_pkg::PROD_W'(step) * fcsb_pkg::PROD_W'(i + 1);
      if ((fcsb_pkg::PROD_W'(level) >= lo_bound[i]) &&
          (fcsb_pkg::PROD_W'(level) <= hi_bound[i])) begin
        hit = 1'b1;
        idx = fcsb_pkg::BAR_IDX_W'(i);
      end
    end
  end

  assign pattern = fcsb_pkg::bar_pattern(idx);

endmodule

### rtl/core/field_change_and_strength_bar.sv
// Top level: run mode, LED logic, configuration registers and result register.
//
// One item is accepted per clock cycle while the result register can take it,
// and its result appears in the output register on the next cycle. All
// per-item work (change test on both bands, baseline LED test and the eight-step
// bar check) is done in one pass between the input handshake and the result
// register, and the held band state is updated at the same edge.
// The result register stalls the input only while it holds an untaken result.
// A capture item starts detect mode; after reset the block is stopped.
`timescale 1ns / 1ps
module field_change_and_strength_bar (
  input  logic                                 clk,
  input  logic                                 rst_n,
  fcsb_in_if.sink                              in_ch,
  fcsb_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [fcsb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcsb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  fcsb_pkg::sel_t      chan_sel_r;
  fcsb_pkg::thresh_t   thresh_r;
  fcsb_pkg::mode_t     mode_r;
  fcsb_pkg::mode_t     mode_nxt;
  fcsb_pkg::led_t      led_r;
  fcsb_pkg::led_t      led_nxt;

  logic                out_valid_r;
  fcsb_pkg::led_t      out_leds_r;
  fcsb_pkg::run_t      out_run_r;
  fcsb_pkg::chan_res_t low_res_r;
  fcsb_pkg::chan_res_t high_res_r;

  logic                accept;
  logic                capture;
  logic                sampling;
  logic                low_on;
  logic                high_on;
  fcsb_pkg::chan_ctrl_t low_ctrl;
  fcsb_pkg::chan_ctrl_t high_ctrl;
  fcsb_pkg::chan_res_t  low_res;
  fcsb_pkg::chan_res_t  high_res;
  logic                low_dev;
  logic                high_dev;
  fcsb_pkg::sample_t   low_level_nxt;
  fcsb_pkg::sample_t   low_peak_nxt;
  fcsb_pkg::sample_t   low_base;
  fcsb_pkg::sample_t   high_level_nxt;
  fcsb_pkg::sample_t   high_peak_nxt;
  fcsb_pkg::sample_t   high_base;
  logic signed [fcsb_pkg::SAMPLE_BITS:0] low_rise;
  logic signed [fcsb_pkg::SAMPLE_BITS:0] high_rise;
  logic                bar_high;
  fcsb_pkg::sample_t   bar_level;
  fcsb_pkg::sample_t   bar_peak;
  logic                bar_hit;
  fcsb_pkg::led_t      bar_leds;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign capture      = (in_ch.opcode == fcsb_pkg::OP_CAPTURE);
  assign low_on       = (chan_sel_r != fcsb_pkg::SEL_HIGH);
  assign high_on      = (chan_sel_r != fcsb_pkg::SEL_LOW);

  // Mode after a capture or the button is applied.
  always_comb begin
    mode_nxt = mode_r;
    if (capture) begin
      mode_nxt = fcsb_pkg::MODE_DETECT;
    end else if (in_ch.button) begin
      case (mode_r)
        fcsb_pkg::MODE_DETECT:   mode_nxt = fcsb_pkg::MODE_STRENGTH;
        fcsb_pkg::MODE_STRENGTH: mode_nxt = fcsb_pkg::MODE_STOPPED;
        default:                 mode_nxt = mode_r;
      endcase
    end
  end

  assign sampling = !capture && (mode_nxt != fcsb_pkg::MODE_STOPPED);

  assign low_ctrl.capture    = accept && capture;
  assign low_ctrl.step       = accept && sampling && low_on;
  assign low_ctrl.enable     = low_on;
  assign low_ctrl.threshold  = thresh_r;
  assign high_ctrl.capture   = accept && capture;
  assign high_ctrl.step      = accept && sampling && high_on;
  assign high_ctrl.enable    = high_on;
  assign high_ctrl.threshold = thresh_r;

  fcsb_chan u_low (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (low_ctrl),
    .sample    (in_ch.low_band_sample),
    .res       (low_res),
    .dev_led   (low_dev),
    .level_nxt (low_level_nxt),
    .peak_nxt  (low_peak_nxt),
    .baseline  (low_base)
  );

  fcsb_chan u_high (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (high_ctrl),
    .sample    (in_ch.high_band_sample),
    .res       (high_res),
    .dev_led   (high_dev),
    .level_nxt (high_level_nxt),
    .peak_nxt  (high_peak_nxt),
    .baseline  (high_base)
  );

  // Bar source: selected band, else larger peak rise over baseline; tie goes to low.
  assign low_rise  = $signed({1'b0, low_peak_nxt}) - $signed({1'b0, low_base});
  assign high_rise = $signed({1'b0, high_peak_nxt}) - $signed({1'b0, high_base});
  assign bar_high  = (chan_sel_r == fcsb_pkg::SEL_HIGH) ||
                     ((chan_sel_r != fcsb_pkg::SEL_LOW) && (high_rise > low_rise));
  assign bar_level = bar_high ? high_level_nxt : low_level_nxt;
  assign bar_peak  = bar_high ? high_peak_nxt  : low_peak_nxt;

  fcsb_bar u_bar (
    .level   (bar_level),
    .peak    (bar_peak),
    .hit     (bar_hit),
    .pattern (bar_leds)
  );

  always_comb begin
    led_nxt = led_r;
    if (capture) begin
      led_nxt = '0;
    end else if (mode_r != fcsb_pkg::MODE_STOPPED) begin
      if (mode_nxt == fcsb_pkg::MODE_STOPPED) begin
        led_nxt = '0;
      end else if (mode_nxt == fcsb_pkg::MODE_DETECT) begin
        if (low_on) begin
          led_nxt[fcsb_pkg::LED_D] = low_dev;
        end
        if (high_on) begin
          led_nxt[fcsb_pkg::LED_B] = high_dev;
        end
      end else if (bar_hit) begin
        led_nxt = bar_leds;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_sel_r <= '0;
      thresh_r   <= fcsb_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fcsb_pkg::CFG_CHANNEL_SELECT:   chan_sel_r <= cfg_wdata[fcsb_pkg::SEL_W-1:0];
        fcsb_pkg::CFG_CHANGE_THRESHOLD: thresh_r   <= cfg_wdata[fcsb_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= fcsb_pkg::MODE_STOPPED;
      led_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r      <= mode_nxt;
        led_r       <= led_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_leds_r <= led_nxt;
      out_run_r  <= fcsb_pkg::run_code(mode_nxt);
      low_res_r  <= low_res;
      high_res_r <= high_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.leds             = out_leds_r;
  assign out_ch.run_mode         = out_run_r;
  assign out_ch.low_change       = low_res_r.change;
  assign out_ch.low_old_level    = low_res_r.old_level;
  assign out_ch.low_new_level    = low_res_r.new_level;
  assign out_ch.low_quiet_count  = low_res_r.quiet_count;
  assign out_ch.high_change      = high_res_r.change;
  assign out_ch.high_old_level   = high_res_r.old_level;
  assign out_ch.high_new_level   = high_res_r.new_level;
  assign out_ch.high_quiet_count = high_res_r.quiet_count;

endmodule

### rtl/core/fcsb_chk.sv
// Port-level checker for the field change and strength bar block, with its bind.
`timescale 1ns / 1ps
module fcsb_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fcsb_pkg::led_t      leds,
  input fcsb_pkg::run_t      run_mode,
  input logic                low_change,
  input fcsb_pkg::sample_t   low_old_level,
  input fcsb_pkg::sample_t   low_new_level,
  input fcsb_pkg::quiet_t    low_quiet_count,
  input logic                high_change,
  input fcsb_pkg::sample_t   high_old_level,
  input fcsb_pkg::sample_t   high_new_level,
  input fcsb_pkg::quiet_t    high_quiet_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_low_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (low_change == (low_old_level != low_new_level)) &&
                  (!low_change || (low_quiet_count != '0)))
    else $error("low band change report inconsistent");

  a_high_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (high_change == (high_old_level != high_new_level)) &&
                  (!high_change || (high_quiet_count != '0)))
    else $error("high band change report inconsistent");

  a_stopped_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (run_mode == fcsb_pkg::RUN_STOPPED) |->
      (leds == '0) && !low_change && !high_change)
    else $error("activity while stopped");

endmodule

bind field_change_and_strength_bar fcsb_chk u_fcsb_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .leds             (out_ch.leds),
  .run_mode         (out_ch.run_mode),
  .low_change       (out_ch.low_change),
  .low_old_level    (out_ch.low_old_level),
  .low_new_level    (out_ch.low_new_level),
  .low_quiet_count  (out_ch.low_quiet_count),
  .high_change      (out_ch.high_change),
  .high_old_level   (out_ch.high_old_level),
  .high_new_level   (out_ch.high_new_level),
  .high_quiet_count (out_ch.high_quiet_count)
);
